>>> hw/rtl/bmg_pkg.sv
// bmg_pkg: shared types, constants and tables for the box-muller gaussian pair core
// no dependencies; imported by the core and its checker
package bmg_pkg;

	// default parameter values
	localparam int MANTISSA_BITS_DEF = 53;
	localparam int OUT_FRAC_BITS     = 18;

	// iteration counts
	localparam int LOG_STEPS    = 30;
	localparam int SQRT_STEPS   = 32;
	localparam int CORDIC_STEPS = 30;

	// fixed-point constants
	localparam logic [27:0] TWO_LN2_Q27    = 28'hB17217F;
	localparam logic [30:0] HALF_PI_Q30    = 31'h6487ED51;
	localparam logic [29:0] CORDIC_GAIN_Q30 = 30'h26DD3B6A;

	// internal datapath widths
	localparam int CW     = 40; // cordic x, y, z
	localparam int OUT_W  = 24;
	localparam logic signed [CW-1:0] OUT_MAX = 40'sd8388607;
	localparam logic signed [CW-1:0] OUT_MIN = -40'sd8388608;

	// pipeline stage map
	localparam int ST_LOG0   = 4;
	localparam int ST_MUL    = ST_LOG0 + LOG_STEPS + 1;
	localparam int ST_SCALE  = ST_MUL + 1;
	localparam int ST_GAIN   = ST_SCALE + SQRT_STEPS + 1;
	localparam int ST_OUT    = ST_GAIN + CORDIC_STEPS + 1;

	typedef struct packed {
		logic [63:0] uniform_bits_first;
		logic [63:0] uniform_bits_second;
	} bmg_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_cos;
		logic signed [OUT_W-1:0] normal_sin;
	} bmg_out_t;

	// cordic arctangent table, radians in q30
	function automatic logic [29:0] atan_q30(input int unsigned idx);
		logic [29:0] v;
		unique case (idx)
			0:  v = 30'h3243F6A8;
			1:  v = 30'h1DAC6705;
			2:  v = 30'h0FADBAFC;
			3:  v = 30'h07F56EA6;
			4:  v = 30'h03FEAB76;
			5:  v = 30'h01FFD55B;
			6:  v = 30'h00FFFAAA;
			7:  v = 30'h007FFF55;
			8:  v = 30'h003FFFEA;
			9:  v = 30'h001FFFFD;
			10: v = 30'h000FFFFF;
			11: v = 30'h0007FFFF;
			12: v = 30'h0003FFFF;
			13: v = 30'h0001FFFF;
			14: v = 30'h0000FFFF;
			15: v = 30'h00007FFF;
			16: v = 30'h00003FFF;
			17: v = 30'h00001FFF;
			18: v = 30'h00000FFF;
			19: v = 30'h000007FF;
			20: v = 30'h000003FF;
			21: v = 30'h000001FF;
			22: v = 30'h000000FF;
			23: v = 30'h0000007F;
			24: v = 30'h0000003F;
			25: v = 30'h0000001F;
			26: v = 30'h0000000F;
			27: v = 30'h00000008;
			28: v = 30'h00000004;
			29: v = 30'h00000002;
			default: v = '0;
		endcase
		return v;
	endfunction

	// index of the highest set bit in a byte
	function automatic logic [2:0] top_one8(input logic [7:0] v);
		logic [2:0] idx;
		idx = '0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) idx = 3'(i);
		end
		return idx;
	endfunction

endpackage

>>> hw/rtl/box_muller_gaussian_pair_core.sv
// box_muller_gaussian_pair_core: fixed-point box-muller normal pair generator
// depends on bmg_pkg
//
//   channel | direction | payload  | handshake
//   uni     | in        | bmg_in_t | uni_valid / uni_stall
//   gauss   | out       | bmg_out_t| gauss_valid / gauss_stall
//
// one transaction in and one out per cycle while no result is held by gauss_stall;
// stages: byte scan and normalize, 30 log2 squaring stages, 32 square root stages,
// 30 cordic stages, rounding into the output register
// arst_n clears only the valid bits; data registers are not reset
// a stalled result freezes the whole pipeline; uni_stall follows gauss_stall
// while a result is held
module box_muller_gaussian_pair_core #(
	parameter int MANTISSA_BITS = bmg_pkg::MANTISSA_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             uni_valid,
	output logic             uni_stall,
	input  bmg_pkg::bmg_in_t uni,
	output logic             gauss_valid,
	input  logic             gauss_stall,
	output bmg_pkg::bmg_out_t gauss
);
	import bmg_pkg::*;

	localparam int DROP = 64 - MANTISSA_BITS;
	localparam logic [63:0] KEEP = ~((64'd1 << DROP) - 64'd1);
	localparam int SH = 28 - OUT_FRAC_BITS;
	localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);

	logic en;
	logic vld_s [1:ST_OUT];

	// global advance: everything moves unless a held result is stalled
	assign uni_stall = gauss_valid && gauss_stall;
	assign en        = !uni_stall;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_OUT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= uni_valid;
			for (int k = 2; k <= ST_OUT; k++) vld_s[k] <= vld_s[k-1];
		end
	end
	assign gauss_valid = vld_s[ST_OUT];

	// stage 1: keep the top mantissa bits
	logic [MANTISSA_BITS-1:0] q_s1;
	logic [31:0]              a_s1;
	logic [63:0]              a_masked;
	assign a_masked = uni.uniform_bits_second & KEEP;
	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= uni.uniform_bits_first[63 -: MANTISSA_BITS];
			a_s1 <= a_masked[63:32];
		end
	end

	// stage 2: r = 1 - u1, byte flags, angle in q30
	logic [63:0] q_full;
	logic [60:0] th_prod;
	logic [63:0] r_s2;
	logic [7:0]  grp_s2;
	logic [32:0] ang_s [2:ST_OUT-1];
	assign q_full  = 64'({q_s1, {DROP{1'b0}}});
	assign th_prod = a_s1[29:0] * HALF_PI_Q30;
	always_ff @(posedge clk) begin
		if (en) begin
			r_s2 <= 64'd0 - q_full;
			for (int g = 0; g < 8; g++) grp_s2[g] <= |((64'd0 - q_full) >> (g * 8)) & 1'b1
				? |(((64'd0 - q_full) >> (g * 8)) & 64'hFF) : 1'b0;
		end
	end

	// angle and quadrant delay line
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s[2] <= {a_s1[31:30], th_prod[60:30]};
			for (int k = 3; k < ST_OUT; k++) ang_s[k] <= ang_s[k-1];
		end
	end

	// stage 3: leading one position
	logic [63:0] r_s3;
	logic [5:0]  e_s3;
	logic        zero_s3;
	logic [2:0]  grp_top;
	assign grp_top = top_one8(grp_s2);
	always_ff @(posedge clk) begin
		if (en) begin
			r_s3    <= r_s2;
			e_s3    <= {grp_top, top_one8(r_s2[grp_top*8 +: 8])};
			zero_s3 <= (grp_s2 == 8'd0);
		end
	end

	// stage 4: normalize to q1.31
	logic [94:0] norm_wide;
	logic [31:0] lg_y_s [0:LOG_STEPS];
	logic [29:0] lg_f_s [0:LOG_STEPS];
	logic [5:0]  lg_e_s [0:LOG_STEPS];
	logic        lg_z_s [0:LOG_STEPS];
	assign norm_wide = {r_s3, 31'd0} >> e_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			lg_y_s[0] <= norm_wide[31:0];
			lg_f_s[0] <= '0;
			lg_e_s[0] <= e_s3;
			lg_z_s[0] <= zero_s3;
		end
	end

	// log2 fraction bits by repeated squaring, one bit per stage
	for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_log
		logic [63:0] sq;
		logic        hi;
		assign sq = lg_y_s[k-1] * lg_y_s[k-1];
		assign hi = sq[63];
		always_ff @(posedge clk) begin
			if (en) begin
				lg_y_s[k] <= hi ? sq[63:32] : sq[62:31];
				lg_f_s[k] <= {lg_f_s[k-1][28:0], hi};
				lg_e_s[k] <= lg_e_s[k-1];
				lg_z_s[k] <= lg_z_s[k-1];
			end
		end
	end

	// -2 ln scaling product
	logic [36:0] d_log;
	logic [64:0] mul_s;
	logic        mul_z_s;
	assign d_log = {7'd64 - {1'b0, lg_e_s[LOG_STEPS]}, 30'd0} - {7'd0, lg_f_s[LOG_STEPS]};
	always_ff @(posedge clk) begin
		if (en) begin
			mul_s   <= 65'(d_log * TWO_LN2_Q27);
			mul_z_s <= lg_z_s[LOG_STEPS];
		end
	end

	// round to q30 and place for the square root
	logic [64:0] mul_rnd;
	logic [63:0] sq_v_s [0:SQRT_STEPS];
	logic [63:0] sq_r_s [0:SQRT_STEPS];
	assign mul_rnd = mul_s + 65'(64'd1 << 26);
	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_s[0] <= mul_z_s ? 64'd0 : {mul_rnd[64:27], 26'd0};
			sq_r_s[0] <= '0;
		end
	end

	// restoring square root, two radicand bits per stage
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] trial;
		assign trial = sq_r_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (sq_v_s[j] >= trial) begin
					sq_v_s[j+1] <= sq_v_s[j] - trial;
					sq_r_s[j+1] <= (sq_r_s[j] >> 1) + BIT;
				end else begin
					sq_v_s[j+1] <= sq_v_s[j];
					sq_r_s[j+1] <= sq_r_s[j] >> 1;
				end
			end
		end
	end

	// cordic gain compensation
	logic [61:0] gain_s;
	always_ff @(posedge clk) begin
		if (en) gain_s <= sq_r_s[SQRT_STEPS][31:0] * CORDIC_GAIN_Q30;
	end

	// cordic rotation, one micro-rotation per stage
	logic signed [CW-1:0] cx_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cy_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cz_s [0:CORDIC_STEPS];
	assign cx_s[0] = $signed({8'd0, gain_s[61:30]});
	assign cy_s[0] = '0;
	assign cz_s[0] = $signed({9'd0, ang_s[ST_GAIN][30:0]});

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CW-1:0] dx, dy, at;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign at = $signed({10'd0, atan_q30(i)});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - at;
				end else begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + at;
				end
			end
		end
	end

	// quadrant fold, rounding and saturation
	logic signed [CW-1:0] c_pre, s_pre;
	logic [1:0] quad;
	assign quad = ang_s[ST_OUT-1][32:31];
	always_comb begin
		unique case (quad)
			2'd0: begin c_pre = cx_s[CORDIC_STEPS];  s_pre = cy_s[CORDIC_STEPS];  end
			2'd1: begin c_pre = -cy_s[CORDIC_STEPS]; s_pre = cx_s[CORDIC_STEPS];  end
			2'd2: begin c_pre = -cx_s[CORDIC_STEPS]; s_pre = -cy_s[CORDIC_STEPS]; end
			default: begin c_pre = cy_s[CORDIC_STEPS]; s_pre = -cx_s[CORDIC_STEPS]; end
		endcase
	end

	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + HALF) >>> SH;
		if (r > OUT_MAX) return OUT_MAX[OUT_W-1:0];
		else if (r < OUT_MIN) return OUT_MIN[OUT_W-1:0];
		else return r[OUT_W-1:0];
	endfunction

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			gauss.normal_cos <= to_out(c_pre);
			gauss.normal_sin <= to_out(s_pre);
		end
	end

endmodule

>>> hw/rtl/bmg_checker.sv
// bmg_checker: port-level assertions for box_muller_gaussian_pair_core
// depends on bmg_pkg; bound to the core below
module bmg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              uni_valid,
	input logic              uni_stall,
	input bmg_pkg::bmg_in_t  uni,
	input logic              gauss_valid,
	input logic              gauss_stall,
	input bmg_pkg::bmg_out_t gauss
);
	import bmg_pkg::*;

	// input is refused exactly while a result is held back
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		uni_stall == (gauss_valid && gauss_stall))
		else $error("uni_stall does not track a held result");

	// a held result keeps its valid and payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		gauss_valid && gauss_stall |=> gauss_valid && $stable(gauss))
		else $error("held result changed");

	// no result while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !gauss_valid)
		else $error("result valid during reset");

endmodule

bind box_muller_gaussian_pair_core bmg_checker u_bmg_checker (.*);
